FILE: design/bfv_pkg.sv
package bfv_pkg;

    localparam int PLANE_COUNT  = 6;
    localparam int POINT_COUNT  = 2;
    localparam int AXES         = 3;
    localparam int NORMAL_W     = 16;
    localparam int COORD_W      = 21;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int LPROD_W      = NORMAL_W + DIFF_W;
    localparam int RPROD_W      = NORMAL_W + COORD_W;
    localparam int LSUM_W       = LPROD_W + 2;
    localparam int RSUM_W       = RPROD_W + 2;
    localparam int NORMAL_REG_W = NORMAL_W * AXES;
    localparam int POINT_REG_W  = COORD_W * AXES;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORMAL_NEAR      = 4'd0,
        REG_NORMAL_LEFT      = 4'd1,
        REG_NORMAL_TOP       = 4'd2,
        REG_NORMAL_BOTTOM    = 4'd3,
        REG_NORMAL_RIGHT     = 4'd4,
        REG_NORMAL_FAR       = 4'd5,
        REG_NEAR_TOP_LEFT    = 4'd6,
        REG_FAR_BOTTOM_RIGHT = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [PLANE_COUNT-1:0][NORMAL_REG_W-1:0] normal;
        logic [POINT_COUNT-1:0][POINT_REG_W-1:0]  point;
    } frustum_t;

endpackage

FILE: design/bfv_if.sv
interface bfv_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bfv_pkg::CFG_IDX_W-1:0]  index;
    logic [bfv_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface bfv_box_if;
    logic                                valid;
    logic                                ready;
    logic signed [bfv_pkg::COORD_W-1:0]  center_x;
    logic signed [bfv_pkg::COORD_W-1:0]  center_y;
    logic signed [bfv_pkg::COORD_W-1:0]  center_z;
    logic signed [bfv_pkg::COORD_W-1:0]  extent_x;
    logic signed [bfv_pkg::COORD_W-1:0]  extent_y;
    logic signed [bfv_pkg::COORD_W-1:0]  extent_z;

    modport source (output valid, output center_x, output center_y, output center_z,
                    output extent_x, output extent_y, output extent_z, input ready);
    modport sink   (input valid, input center_x, input center_y, input center_z,
                    input extent_x, input extent_y, input extent_z, output ready);
endinterface

interface bfv_vis_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, output visible, input ready);
    modport sink   (input valid, input visible, output ready);
endinterface

FILE: design/box_frustum_visibility_test.sv
// An accepted word passes the difference, product, plane sum and output registers in
// order, and its result is then valid at the output until it is taken.
// Throughput: one box per cycle while vis.ready holds, set by the four-stage pipeline
// of differences, products, plane sums and the final compare into the output register.
// Reset clears all stage valid bits and sets every normal and point register to zero,
// so that every box is reported visible until the frustum is written.
module box_frustum_visibility_test (
    input  logic      clk,
    input  logic      rst_n,
    bfv_cfg_if.sink   cfg,
    bfv_box_if.sink   box,
    bfv_vis_if.source vis
);

    bfv_pkg::frustum_t frustum;

    bfv_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .frustum (frustum)
    );

    bfv_pipe u_pipe (
        .clk     (clk),
        .rst_n   (rst_n),
        .frustum (frustum),
        .box     (box),
        .vis     (vis)
    );

    // The input side only stalls when the whole pipeline is full behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !box.ready |-> (vis.valid && !vis.ready))
        else $error("input stalled while the pipeline had room");

    // With the result side ready throughout, an accepted word must reach the output in time.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1)
         && $past(box.valid && box.ready, 3)
         && $past(vis.ready, 2) && $past(vis.ready, 1) && vis.ready) |=> vis.valid)
        else $error("accepted word did not reach the output in time");

    // The configuration port never holds off a write.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid |-> cfg.ready)
        else $error("configuration write refused");

endmodule

FILE: design/bfv_cfg_regs.sv
module bfv_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    bfv_cfg_if.sink           cfg,
    output bfv_pkg::frustum_t frustum
);

    bfv_pkg::frustum_t frustum_reg;
    bfv_pkg::frustum_t frustum_next;

    assign cfg.ready = 1'b1;
    assign frustum   = frustum_reg;

    always_comb
    begin
        frustum_next = frustum_reg;
        if (cfg.valid)
        begin
            case (bfv_pkg::cfg_reg_t'(cfg.index))
                bfv_pkg::REG_NORMAL_NEAR:
                    frustum_next.normal[0] = cfg.data[bfv_pkg::NORMAL_REG_W-1:0];
                bfv_pkg::REG_NORMAL_LEFT:
                    frustum_next.normal[1] = cfg.data[bfv_pkg::NORMAL_REG_W-1:0];
                bfv_pkg::REG_NORMAL_TOP:
                    frustum_next.normal[2] = cfg.data[bfv_pkg::NORMAL_REG_W-1:0];
                bfv_pkg::REG_NORMAL_BOTTOM:
                    frustum_next.normal[3] = cfg.data[bfv_pkg::NORMAL_REG_W-1:0];
                bfv_pkg::REG_NORMAL_RIGHT:
                    frustum_next.normal[4] = cfg.data[bfv_pkg::NORMAL_REG_W-1:0];
                bfv_pkg::REG_NORMAL_FAR:
                    frustum_next.normal[5] = cfg.data[bfv_pkg::NORMAL_REG_W-1:0];
                bfv_pkg::REG_NEAR_TOP_LEFT:
                    frustum_next.point[0] = cfg.data[bfv_pkg::POINT_REG_W-1:0];
                bfv_pkg::REG_FAR_BOTTOM_RIGHT:
                    frustum_next.point[1] = cfg.data[bfv_pkg::POINT_REG_W-1:0];
                default:
                    frustum_next = frustum_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frustum_reg <= '0;
        end
        else
        begin
            frustum_reg <= frustum_next;
        end
    end

endmodule

FILE: design/bfv_pipe.sv
module bfv_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  bfv_pkg::frustum_t frustum,
    bfv_box_if.sink           box,
    bfv_vis_if.source         vis
);

    localparam int PC = bfv_pkg::PLANE_COUNT;
    localparam int NA = bfv_pkg::AXES;
    localparam int NW = bfv_pkg::NORMAL_W;
    localparam int CW = bfv_pkg::COORD_W;

    function automatic logic [NW-1:0] mag_normal(input logic [NW-1:0] v);
        return v[NW-1] ? (~v + 1'b1) : v;
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic en1, en2, en3, en4;

    logic signed [CW-1:0] ctr [NA];
    logic signed [CW-1:0] ext [NA];

    logic signed [bfv_pkg::DIFF_W-1:0]  d1_reg  [bfv_pkg::POINT_COUNT][NA];
    logic signed [bfv_pkg::DIFF_W-1:0]  d1_next [bfv_pkg::POINT_COUNT][NA];
    logic        [CW-1:0]               h1_reg  [NA];
    logic        [CW-1:0]               h1_next [NA];
    logic signed [bfv_pkg::LPROD_W-1:0] lp2_reg  [PC][NA];
    logic signed [bfv_pkg::LPROD_W-1:0] lp2_next [PC][NA];
    logic        [bfv_pkg::RPROD_W-1:0] rp2_reg  [PC][NA];
    logic        [bfv_pkg::RPROD_W-1:0] rp2_next [PC][NA];
    logic signed [bfv_pkg::LSUM_W-1:0]  ls3_reg  [PC];
    logic signed [bfv_pkg::LSUM_W-1:0]  ls3_next [PC];
    logic        [bfv_pkg::RSUM_W-1:0]  rs3_reg  [PC];
    logic        [bfv_pkg::RSUM_W-1:0]  rs3_next [PC];
    logic [PC-1:0] reject;
    logic          vis_reg;
    logic          vis_next;

    // A stage takes a new word when it is empty or its contents move on.
    assign en4 = !v4_reg || vis.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign box.ready   = en1;
    assign vis.valid   = v4_reg;
    assign vis.visible = vis_reg;

    assign v1_next = en1 ? box.valid : v1_reg;
    assign v2_next = en2 ? v1_reg : v2_reg;
    assign v3_next = en3 ? v2_reg : v3_reg;
    assign v4_next = en4 ? v3_reg : v4_reg;

    assign ctr[0] = box.center_x;
    assign ctr[1] = box.center_y;
    assign ctr[2] = box.center_z;
    assign ext[0] = box.extent_x;
    assign ext[1] = box.extent_y;
    assign ext[2] = box.extent_z;

    always_comb
    begin
        for (int a = 0; a < NA; a++)
        begin
            h1_next[a] = ext[a][CW-1] ? (~$unsigned(ext[a]) + 1'b1) : $unsigned(ext[a]);
            for (int p = 0; p < bfv_pkg::POINT_COUNT; p++)
            begin
                d1_next[p][a] = bfv_pkg::DIFF_W'(ctr[a])
                    - bfv_pkg::DIFF_W'($signed(frustum.point[p][a*CW +: CW]));
            end
        end
    end

    always_comb
    begin
        for (int pl = 0; pl < PC; pl++)
        begin
            for (int a = 0; a < NA; a++)
            begin
                lp2_next[pl][a] =
                    bfv_pkg::LPROD_W'($signed(frustum.normal[pl][a*NW +: NW]))
                    * bfv_pkg::LPROD_W'(d1_reg[pl >= PC/2][a]);
                rp2_next[pl][a] =
                    bfv_pkg::RPROD_W'(mag_normal(frustum.normal[pl][a*NW +: NW]))
                    * bfv_pkg::RPROD_W'(h1_reg[a]);
            end
        end
    end

    always_comb
    begin
        for (int pl = 0; pl < PC; pl++)
        begin
            ls3_next[pl] = bfv_pkg::LSUM_W'(lp2_reg[pl][0]) + bfv_pkg::LSUM_W'(lp2_reg[pl][1])
                + bfv_pkg::LSUM_W'(lp2_reg[pl][2]);
            rs3_next[pl] = bfv_pkg::RSUM_W'(rp2_reg[pl][0]) + bfv_pkg::RSUM_W'(rp2_reg[pl][1])
                + bfv_pkg::RSUM_W'(rp2_reg[pl][2]);
        end
    end

    always_comb
    begin
        for (int pl = 0; pl < PC; pl++)
        begin
            reject[pl] = ls3_reg[pl] > $signed({1'b0, rs3_reg[pl]});
        end
        vis_next = ~|reject;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            d1_reg <= d1_next;
            h1_reg <= h1_next;
        end
        if (en2)
        begin
            lp2_reg <= lp2_next;
            rp2_reg <= rp2_next;
        end
        if (en3)
        begin
            ls3_reg <= ls3_next;
            rs3_reg <= rs3_next;
        end
        if (en4)
        begin
            vis_reg <= vis_next;
        end
    end

endmodule
